// ===== src/satellite_elevation_angle_unit_macros.svh =====
// assertion helpers for the elevation unit
`ifndef SATELLITE_ELEVATION_ANGLE_UNIT_MACROS_SVH
`define SATELLITE_ELEVATION_ANGLE_UNIT_MACROS_SVH
// implication checked on every clock, off during reset
`define SEA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// implication whose consequent is checked on the next clock
`define SEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ===== src/sea_pkg.sv =====
package sea_pkg;
	localparam int STEPS = 32;
	localparam int ZW = 40;
	localparam int NW = 32;
	// atan(2^-i) in nano-degrees
	function automatic logic [ZW-1:0] atan_nano(input int i);
		logic [ZW-1:0] t;
		begin
			case (i)
				0: t = 40'd45000000000;
				1: t = 40'd26565051177;
				2: t = 40'd14036243468;
				3: t = 40'd7125016349;
				4: t = 40'd3576334375;
				5: t = 40'd1789910608;
				6: t = 40'd895173710;
				7: t = 40'd447614171;
				8: t = 40'd223810500;
				9: t = 40'd111905677;
				10: t = 40'd55952892;
				11: t = 40'd27976453;
				12: t = 40'd13988227;
				13: t = 40'd6994114;
				default: t = (40'd57295779513 + (40'd1 << (i - 1))) >> i;
			endcase
			return t;
		end
	endfunction
endpackage

// ===== src/sea_if.sv =====
interface sea_in_if #(parameter int CW = 27);
	logic valid;
	logic ready;
	logic signed [CW-1:0] sat_x, sat_y, sat_z, rx_x, rx_y, rx_z;
	modport source(output valid, sat_x, sat_y, sat_z, rx_x, rx_y, rx_z, input ready);
	modport sink(input valid, sat_x, sat_y, sat_z, rx_x, rx_y, rx_z, output ready);
endinterface

interface sea_out_if #(parameter int EW = 18);
	logic valid;
	logic ready;
	logic signed [EW-1:0] elevation;
	logic valid_res;
	modport source(output valid, elevation, valid_res, input ready);
	modport sink(input valid, elevation, valid_res, output ready);
endinterface

// ===== src/sea_sqrt_cell.sv =====
// one digit of the restoring square root
module sea_sqrt_cell #(
	parameter int SHIFT = 62
) (
	input  logic        clk,
	input  logic        en,
	input  logic [63:0] q_in,
	input  logic [63:0] r_in,
	output logic [63:0] q_q,
	output logic [63:0] r_q
);
	localparam logic [63:0] BIT = 64'd1 << SHIFT;
	logic [64:0] trial;
	assign trial = {1'b0, r_in} + {1'b0, BIT};
	always_ff @(posedge clk) begin
		if (en) begin
			if ({1'b0, q_in} >= trial) begin
				q_q <= q_in - trial[63:0];
				r_q <= (r_in >> 1) + BIT;
			end else begin
				q_q <= q_in;
				r_q <= r_in >> 1;
			end
		end
	end
endmodule

// ===== src/sea_cordic_cell.sv =====
// one vectoring rotation
module sea_cordic_cell #(
	parameter int IDX = 0
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [sea_pkg::NW+2:0] x_in,
	input  logic signed [sea_pkg::NW+2:0] y_in,
	input  logic signed [sea_pkg::ZW:0]   z_in,
	output logic signed [sea_pkg::NW+2:0] x_q,
	output logic signed [sea_pkg::NW+2:0] y_q,
	output logic signed [sea_pkg::ZW:0]   z_q
);
	localparam logic signed [sea_pkg::ZW:0] ANG = {1'b0, sea_pkg::atan_nano(IDX)};
	always_ff @(posedge clk) begin
		if (en) begin
			if (!y_in[sea_pkg::NW+2]) begin
				x_q <= x_in + (y_in >>> IDX);
				y_q <= y_in - (x_in >>> IDX);
				z_q <= z_in + ANG;
			end else begin
				x_q <= x_in - (y_in >>> IDX);
				y_q <= y_in + (x_in >>> IDX);
				z_q <= z_in - ANG;
			end
		end
	end
endmodule

// ===== src/satellite_elevation_angle_unit.sv =====
// Elevation of a satellite above the geocentric horizon of a receiver, one
// transaction per cycle unless stalled. The pipeline has five front stages (difference,
// products, cross and dot, normalize, sum of squares), a 32-cell square root chain,
// a 32-cell CORDIC chain and two scaling stages; the whole chain stalls when the
// output is not taken. valid_res is 0 with elevation 0 when either vector is zero.
`include "satellite_elevation_angle_unit_macros.svh"
module satellite_elevation_angle_unit #(
	parameter int COORD_BITS = 27,
	parameter int ANGLE_FRAC_BITS = 10
) (
	input logic clk,
	input logic arst_n,
	sea_in_if.sink   in_ch,
	sea_out_if.source out_ch
);
	localparam int NW = sea_pkg::NW;
	localparam int ZW = sea_pkg::ZW;
	localparam int STEPS = sea_pkg::STEPS;
	localparam int EW = ANGLE_FRAC_BITS + 8;
	localparam int PRE = 5;
	localparam int DEPTH = PRE + 32 + STEPS + 2;
	typedef logic signed [31:0] v31_t;

	logic en;
	logic [DEPTH-1:0] vld_q;
	assign en = !vld_q[DEPTH-1] || out_ch.ready;
	assign in_ch.ready = en;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (en) vld_q <= {vld_q[DEPTH-2:0], in_ch.valid};
	end

	// reduce a vector so all magnitudes are below 2^30
	function automatic void shrink(input logic signed [COORD_BITS:0] a0, a1, a2,
		output v31_t b0, b1, b2);
		logic [COORD_BITS:0] m0, m1, m2, mx;
		int s;
		begin
			m0 = a0[COORD_BITS] ? -a0 : a0;
			m1 = a1[COORD_BITS] ? -a1 : a1;
			m2 = a2[COORD_BITS] ? -a2 : a2;
			mx = m0 | m1 | m2;
			s = 0;
			for (int k = 30; k <= COORD_BITS; k++) if (mx[k]) s = k - 29;
			m0 = m0 >> s; m1 = m1 >> s; m2 = m2 >> s;
			b0 = a0[COORD_BITS] ? -v31_t'(m0) : v31_t'(m0);
			b1 = a1[COORD_BITS] ? -v31_t'(m1) : v31_t'(m1);
			b2 = a2[COORD_BITS] ? -v31_t'(m2) : v31_t'(m2);
		end
	endfunction

	// stage 1: difference, shrink, zero check
	v31_t d_s1 [3];
	v31_t r_s1 [3];
	logic ok_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [COORD_BITS:0] dx, dy, dz, rx, ry, rz;
			v31_t d0, d1, d2, r0, r1, r2;
			dx = in_ch.sat_x - in_ch.rx_x; dy = in_ch.sat_y - in_ch.rx_y;
			dz = in_ch.sat_z - in_ch.rx_z;
			rx = in_ch.rx_x; ry = in_ch.rx_y; rz = in_ch.rx_z;
			shrink(dx, dy, dz, d0, d1, d2);
			shrink(rx, ry, rz, r0, r1, r2);
			d_s1[0] <= d0; d_s1[1] <= d1; d_s1[2] <= d2;
			r_s1[0] <= r0; r_s1[1] <= r1; r_s1[2] <= r2;
			ok_s1 <= (dx != 0 || dy != 0 || dz != 0) && (rx != 0 || ry != 0 || rz != 0);
		end
	end

	// stage 2: products
	logic signed [63:0] pr_s2 [9];
	logic ok_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) pr_s2[3*i+j] <= 64'(d_s1[i]) * 64'(r_s1[j]);
			ok_s2 <= ok_s1;
		end
	end

	// stage 3: cross and dot magnitudes
	logic [63:0] u_s3 [4];
	logic neg_s3, ok_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [63:0] c0, c1, c2, dt;
			c0 = pr_s2[5] - pr_s2[7];
			c1 = pr_s2[6] - pr_s2[2];
			c2 = pr_s2[1] - pr_s2[3];
			dt = pr_s2[0] + pr_s2[4] + pr_s2[8];
			u_s3[0] <= c0[63] ? -c0 : c0;
			u_s3[1] <= c1[63] ? -c1 : c1;
			u_s3[2] <= c2[63] ? -c2 : c2;
			u_s3[3] <= dt[63] ? -dt : dt;
			neg_s3 <= dt[63];
			ok_s3 <= ok_s2;
		end
	end

	// stage 4: normalize max into [2^30, 2^31)
	logic [NW-1:0] n_s4 [4];
	logic neg_s4, ok_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [63:0] mx;
			int msb;
			mx = u_s3[0] | u_s3[1] | u_s3[2] | u_s3[3];
			msb = 30;
			for (int k = 0; k < 64; k++) if (mx[k]) msb = k;
			for (int k = 0; k < 4; k++)
				n_s4[k] <= (msb >= 30) ? NW'(u_s3[k] >> (msb - 30)) : NW'(u_s3[k] << (30 - msb));
			neg_s4 <= neg_s3;
			ok_s4 <= ok_s3 && (mx != 0);
		end
	end

	// stage 5: sum of squares
	logic [63:0] sq_s5;
	logic signed [NW+2:0] y_s5;
	logic ok_s5;
	always_ff @(posedge clk) begin
		if (en) begin
			sq_s5 <= n_s4[0] * n_s4[0] + n_s4[1] * n_s4[1] + n_s4[2] * n_s4[2];
			y_s5 <= neg_s4 ? -$signed({3'b0, n_s4[3]}) : $signed({3'b0, n_s4[3]});
			ok_s5 <= ok_s4;
		end
	end

	// square root chain, y and valid ride along
	logic [63:0] sq [33];
	logic [63:0] rt [33];
	logic signed [NW+2:0] yd_q [33];
	logic okd_q [33];
	assign sq[0] = sq_s5;
	assign rt[0] = '0;
	assign yd_q[0] = y_s5;
	assign okd_q[0] = ok_s5;
	for (genvar g = 0; g < 32; g++) begin : g_sqrt
		sea_sqrt_cell #(.SHIFT(62 - 2*g)) u_cell (
			.clk(clk), .en(en), .q_in(sq[g]), .r_in(rt[g]), .q_q(sq[g+1]), .r_q(rt[g+1]));
		always_ff @(posedge clk) if (en) begin
			yd_q[g+1] <= yd_q[g];
			okd_q[g+1] <= okd_q[g];
		end
	end

	// cordic chain
	logic signed [NW+2:0] cx [STEPS+1];
	logic signed [NW+2:0] cy [STEPS+1];
	logic signed [ZW:0] cz [STEPS+1];
	logic okc_q [STEPS+1];
	assign cx[0] = $signed({3'b0, rt[32][NW-1:0]});
	assign cy[0] = yd_q[32];
	assign cz[0] = '0;
	assign okc_q[0] = okd_q[32];
	for (genvar g = 0; g < STEPS; g++) begin : g_cordic
		sea_cordic_cell #(.IDX(g)) u_cell (
			.clk(clk), .en(en), .x_in(cx[g]), .y_in(cy[g]), .z_in(cz[g]),
			.x_q(cx[g+1]), .y_q(cy[g+1]), .z_q(cz[g+1]));
		always_ff @(posedge clk) if (en) okc_q[g+1] <= okc_q[g];
	end

	// scaling: round(|z| * 2^F / 10^9) is ((|z| * 2^F + 5*10^8) >> 9) / 5^9,
	// the divide done as a reciprocal multiply in four partial products;
	// |z| stays below 2^37 since the sum of all rotation angles is under 100 degrees
	localparam int ZA_W = 37;
	localparam int MW = ZA_W + ANGLE_FRAC_BITS - 8;
	localparam int RS = MW + 21;
	localparam int KW = MW + 1;
	localparam int PW = MW + KW;
	localparam int SP = (MW + 1) / 2;
	localparam logic [KW-1:0] RECIP = KW'(((128'd1 << RS) + 128'd1953124) / 128'd1953125);
	localparam logic [PW-1:0] K_LO = PW'(RECIP[SP-1:0]);
	localparam logic [PW-1:0] K_HI = PW'(RECIP[KW-1:SP]);
	localparam logic [EW-1:0] LIM = EW'(90 << ANGLE_FRAC_BITS);

	// scale stage one: magnitude, prescale and partial products
	logic [PW-1:0] pp_s70 [4];
	logic neg_s70, ok_s70;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [ZA_W-1:0] za;
			logic [MW+8:0] nz;
			logic [PW-1:0] m_lo, m_hi;
			za = cz[STEPS][ZW] ? ZA_W'(-cz[STEPS]) : cz[STEPS][ZA_W-1:0];
			nz = (MW+9)'(za) << ANGLE_FRAC_BITS;
			nz = nz + (MW+9)'(500000000);
			m_lo = PW'(nz[SP+8:9]);
			m_hi = PW'(nz[MW+8:SP+9]);
			pp_s70[0] <= m_lo * K_LO;
			pp_s70[1] <= m_lo * K_HI;
			pp_s70[2] <= m_hi * K_LO;
			pp_s70[3] <= m_hi * K_HI;
			neg_s70 <= cz[STEPS][ZW];
			ok_s70 <= okc_q[STEPS];
		end
	end

	// scale stage two: sum, limit and sign
	logic signed [EW-1:0] elev_q;
	logic vres_q;
	always_ff @(posedge clk) begin
		if (en) begin
			logic [PW-1:0] p;
			logic [EW-1:0] q;
			p = pp_s70[0] + (pp_s70[1] << SP) + (pp_s70[2] << SP) + (pp_s70[3] << (2 * SP));
			if (p[PW-1:RS] > {1'b0, LIM}) q = LIM;
			else q = p[RS+EW-1:RS];
			if (!ok_s70) elev_q <= '0;
			else elev_q <= neg_s70 ? -q : q;
			vres_q <= ok_s70;
		end
	end

	assign out_ch.valid = vld_q[DEPTH-1];
	assign out_ch.elevation = elev_q;
	assign out_ch.valid_res = vres_q;

	`SEA_ASSERT_IMP(a_stall_ready, clk, arst_n, out_ch.valid && !out_ch.ready, !in_ch.ready)
	`SEA_ASSERT_IMP(a_invalid_zero, clk, arst_n, out_ch.valid && !out_ch.valid_res, out_ch.elevation == 0)
	`SEA_ASSERT_NEXT(a_hold, clk, arst_n, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.elevation))
endmodule
